// ===== rtl/core/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 transcoder
`default_nettype none

package u8u16_pkg;

  // one input request: a raw utf-8 byte and its end-of-text mark
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // one result request: a utf-16 unit with its flags
  typedef struct packed {
    logic [15:0] code_unit;
    logic        decode_error;
    logic        last_of_run;
    logic        text_done;
  } out_item_t;

  // results produced by one decoded byte, handed to the output queue
  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  // byte class masks and codes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  // surrogate construction
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

  // overlong limits on the second byte of three and four byte sequences
  localparam logic [5:0] OVL3_LIMIT = 6'h20;
  localparam logic [5:0] OVL4_LIMIT = 6'h10;

endpackage

`default_nettype wire

// ===== rtl/core/u8u16_decoder.sv =====
// per-byte sequence decoder with pending-sequence state and surrogate split
`default_nettype none

module u8u16_decoder
  import u8u16_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     item_valid,
  input  wire in_item_t item,
  input  wire logic     check_overlong,
  input  wire logic [1:0] free_slots,
  output logic          fire,
  output push_t         push
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] ps_r, ps_nxt;
  logic        ovs_r, ovs_nxt;
  logic        err_r, err_nxt;

  logic        give_err;
  logic        give_sc;
  logic [20:0] sc;
  logic [20:0] sc_off;
  logic [5:0]  low;
  logic        over;
  logic [20:0] ps_shift;
  logic [1:0]  pend_dec;
  logic [7:0]  b;
  logic        eot;
  push_t       res;

  assign b        = item.text_byte;
  assign eot      = item.end_of_text;
  assign low      = b[5:0];
  assign ps_shift = {ps_r[14:0], low};
  assign pend_dec = pend_r - 2'd1;

  // next state of the sequence tracker
  always_comb begin
    pend_nxt = pend_r;
    ps_nxt   = ps_r;
    ovs_nxt  = ovs_r;
    err_nxt  = err_r;
    give_err = 1'b0;
    give_sc  = 1'b0;
    sc       = '0;
    over     = 1'b0;
    if (err_r) begin
      // drop bytes until the end of the text
      if (eot) begin
        pend_nxt = '0;
        ps_nxt   = '0;
        ovs_nxt  = 1'b0;
        err_nxt  = 1'b0;
      end
    end else if (pend_r == 2'd0) begin
      if (!b[7]) begin
        give_sc = 1'b1;
        sc      = {13'd0, b};
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        ps_nxt   = {16'd0, b[4:0]};
        pend_nxt = 2'd1;
        ovs_nxt  = (b[4:1] == 4'd0);
        give_err = eot;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        ps_nxt   = {17'd0, b[3:0]};
        pend_nxt = 2'd2;
        ovs_nxt  = (b[3:0] == 4'd0);
        give_err = eot;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        ps_nxt   = {18'd0, b[2:0]};
        pend_nxt = 2'd3;
        ovs_nxt  = (b[2:0] == 3'd0);
        give_err = eot;
      end else begin
        give_err = 1'b1;
      end
    end else begin
      if ((b & CONT_MASK) != CONT_CODE) begin
        give_err = 1'b1;
      end else begin
        if (ovs_r && check_overlong) begin
          case (pend_r)
            2'd1:    over = 1'b1;
            2'd2:    over = (low < OVL3_LIMIT);
            default: over = (low < OVL4_LIMIT);
          endcase
        end
        if (over) begin
          give_err = 1'b1;
        end else begin
          ovs_nxt  = 1'b0;
          ps_nxt   = ps_shift;
          pend_nxt = pend_dec;
          if (pend_dec == 2'd0) begin
            sc      = ps_shift;
            ps_nxt  = '0;
            give_sc = 1'b1;
          end else begin
            give_err = eot;
          end
        end
      end
    end
    // an error or a finished text clears the tracker; an error before the end of the text then sets the error latch
    if (give_err || (give_sc && eot)) begin
      pend_nxt = '0;
      ps_nxt   = '0;
      ovs_nxt  = 1'b0;
      err_nxt  = 1'b0;
    end
    if (give_err && !eot) begin
      err_nxt = 1'b1;
    end
  end

  // result formation: single unit, surrogate pair or error
  assign sc_off = sc - SUPP_BASE;

  always_comb begin
    res = '0;
    if (give_err) begin
      res.n                  = 2'd1;
      res.item0.decode_error = 1'b1;
      res.item0.last_of_run  = 1'b1;
      res.item0.text_done    = eot;
    end else if (give_sc) begin
      if (sc < SUPP_BASE) begin
        res.n                 = 2'd1;
        res.item0.code_unit   = sc[15:0];
        res.item0.last_of_run = 1'b1;
        res.item0.text_done   = eot;
      end else begin
        res.n                 = 2'd2;
        res.item0.code_unit   = SURR_HI_BASE + {6'd0, sc_off[19:10]};
        res.item1.code_unit   = SURR_LO_BASE + {6'd0, sc_off[9:0]};
        res.item1.last_of_run = 1'b1;
        res.item1.text_done   = eot;
      end
    end
  end

  // decode only when the queue has room for every result of this byte
  assign fire = item_valid && (res.n <= free_slots);

  always_comb begin
    push   = res;
    push.n = fire ? res.n : 2'd0;
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      ps_r   <= '0;
      ovs_r  <= 1'b0;
      err_r  <= 1'b0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      ps_r   <= ps_nxt;
      ovs_r  <= ovs_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8u16_out_queue.sv =====
// two-entry result queue taking up to two results per cycle, one out per cycle while out_stall is low
`default_nettype none

module u8u16_out_queue
  import u8u16_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  out_stall,
  output logic       out_valid,
  output out_item_t  out_item,
  output logic [1:0] free_slots
);

  out_item_t  q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid  = (count_r != 2'd0);
  assign out_item   = q_r[rd_r];
  assign pop        = out_valid && !out_stall;
  assign free_slots = 2'd2 - count_r + {1'b0, pop};

  // pointer and fill count update
  assign wr_nxt    = wr_r ^ push.n[0];
  assign rd_nxt    = rd_r ^ pop;
  assign count_nxt = count_r + push.n - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_r] <= push.item0;
    end
    if (push.n == 2'd2) begin
      q_r[~wr_r] <= push.item1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// top level of the utf-8 to utf-16 transcoder
// Usage:
//   in_valid/in_stall/in_item carry one utf-8 byte per request, with a mark on
//   the last byte of the text. out_valid/out_stall/out_item carry utf-16 code
//   units, error results and the end-of-run and end-of-text marks.
//   cfg_we/cfg_wdata write the overlong check enable; write only while idle.
// Flow: an accepted byte is held in the input stage register, decoded once
//   the result queue has room, and its results are shown from that queue.
// Throughput: one byte per cycle while the output does not stall. A scalar
//   above the basic plane gives a surrogate pair, two results; a byte is
//   decoded only when the two-entry result queue has room for all of them.
// Stall: when out_stall holds, the queue fills; the decode stage waits for
//   room for all results of its byte and in_stall rises only then. An
//   accepted byte is never lost.
// Reset: rst_n synchronous active low clears the input stage, the queue, the
//   pending sequence and the error latch; overlong checking resets to off.
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       chk_ovl_r;
  logic       fire;
  logic [1:0] free_slots;
  push_t      push;

  // input stage holds a byte until it is decoded
  assign in_stall = in_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_item;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_ovl_r <= 1'b0;
    end else if (cfg_we) begin
      chk_ovl_r <= cfg_wdata;
    end
  end

  u8u16_decoder u_decoder (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (in_valid_r),
    .item           (in_item_r),
    .check_overlong (chk_ovl_r),
    .free_slots     (free_slots),
    .fire           (fire),
    .push           (push)
  );

  u8u16_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .free_slots (free_slots)
  );

endmodule

`default_nettype wire

// ===== rtl/core/u8u16_checker.sv =====
// port-level checks for the transcoder, bound to the top level
`default_nettype none

module u8u16_checker
  import u8u16_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // a stalled result stays on the port unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // an error result carries a zero code unit
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.decode_error |-> out_item.code_unit == 16'd0)
    else $error("error result with non-zero code unit");

  // end of text only on the last result of a byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.text_done |-> out_item.last_of_run)
    else $error("text_done without last_of_run");

  // a result that is not last is a high surrogate, followed by a low one
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_of_run |->
      out_item.code_unit[15:10] == 6'b110110 && !out_item.decode_error
      ##1 out_valid && out_item.code_unit[15:10] == 6'b110111 &&
      out_item.last_of_run)
    else $error("surrogate pair malformed");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);

`default_nettype wire
